// File: rtl/core/config_reply_frame_parser_defines.svh
// assertion helpers for the reply frame parser
`ifndef CONFIG_REPLY_FRAME_PARSER_DEFINES_SVH
`define CONFIG_REPLY_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CRFP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crfp check failed");

// next-cycle implication, checked out of reset
`define CRFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crfp check failed");

`endif

// File: rtl/core/crfp_pkg.sv
package crfp_pkg;

   typedef enum logic [3:0] {
      PH_VERSION = 4'd0,
      PH_SID1    = 4'd1,
      PH_SID2    = 4'd2,
      PH_SID3    = 4'd3,
      PH_COUNTER = 4'd4,
      PH_TYPE    = 4'd5,
      PH_SERIAL  = 4'd6,
      PH_MARKER  = 4'd7,
      PH_OPCODE  = 4'd8,
      PH_RETCODE = 4'd9,
      PH_PAYLOAD = 4'd10
   } phase_type;

   localparam logic [3:0] KIND_VERSION    = 4'd0;
   localparam logic [3:0] KIND_SID1       = 4'd1;
   localparam logic [3:0] KIND_SID2       = 4'd2;
   localparam logic [3:0] KIND_SID3       = 4'd3;
   localparam logic [3:0] KIND_COUNTER    = 4'd4;
   localparam logic [3:0] KIND_TYPE_CHAR  = 4'd5;
   localparam logic [3:0] KIND_TYPE_END   = 4'd6;
   localparam logic [3:0] KIND_SERIAL_CHR = 4'd7;
   localparam logic [3:0] KIND_SERIAL_END = 4'd8;
   localparam logic [3:0] KIND_MARKER     = 4'd9;
   localparam logic [3:0] KIND_OPCODE_RC  = 4'd10;
   localparam logic [3:0] KIND_PAYLOAD    = 4'd11;

   localparam logic [2:0] VERDICT_OK          = 3'd0;
   localparam logic [2:0] VERDICT_BAD_VERSION = 3'd1;
   localparam logic [2:0] VERDICT_TOO_SHORT   = 3'd2;
   localparam logic [2:0] VERDICT_SENDER_BAD  = 3'd3;
   localparam logic [2:0] VERDICT_FAILED      = 3'd4;
   localparam logic [2:0] VERDICT_UNKNOWN     = 3'd5;
   localparam logic [2:0] VERDICT_NO_RC       = 3'd6;

   localparam logic [7:0] VERSION_BYTE = 8'h02;
   localparam logic [7:0] STRING_TERM  = 8'h00;

   localparam logic [7:0] RC_FAILED    = 8'h00;
   localparam logic [7:0] RC_SUCCESS   = 8'h01;
   localparam logic [7:0] RC_REBOOT    = 8'h02;
   localparam logic [7:0] RC_FAILED_2  = 8'h03;

   localparam logic [7:0] OPCODE_POS   = 8'd1;

endpackage

// File: rtl/core/config_reply_frame_parser.sv
// reply frame parser: tags each byte and gives a verdict on the final byte
// the result of a req transfer is registered in the rsp register, valid in the cycle after the transfer
// throughput: one byte per cycle; the single rsp register sets it and a new
// byte is taken whenever that register is empty or being drained
// reset clears the parse phase, counters, flags, the sender id and rsp_valid
`include "config_reply_frame_parser_defines.svh"

module config_reply_frame_parser #(
   parameter int unsigned POS_LIMIT = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_field_kind,
   output logic [7:0]  rsp_field_pos,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_frame_done,
   output logic [2:0]  rsp_verdict,
   output logic        rsp_reboot_flag
);

   localparam int unsigned POS_CAP_INT = (POS_LIMIT < 255) ? POS_LIMIT : 255;
   localparam logic [7:0]  POS_CAP     = POS_CAP_INT[7:0];

   crfp_pkg::phase_type phase_ff, phase_in, step_phase;
   logic [7:0]  cnt_ff, cnt_in, cnt_bump;
   logic        version_bad_ff, version_bad_in, step_version_bad;
   logic        sender_bad_ff, sender_bad_in, step_sender_bad;
   logic [7:0]  rc_ff, rc_in, step_rc;
   logic        rc_seen_ff, rc_seen_in, step_rc_seen;
   logic [23:0] sender_id_ff;

   logic        rsp_valid_ff;
   logic [3:0]  kind_ff, kind_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  byte_ff;
   logic        done_ff;
   logic [2:0]  verdict_ff, verdict_in;
   logic        reboot_ff, reboot_in;

   logic        req_xfer;
   logic [7:0]  sid_byte;
   logic        is_term;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign is_term   = (req_frame_byte == crfp_pkg::STRING_TERM);
   assign cnt_bump  = (cnt_ff < POS_CAP) ? cnt_ff + 8'd1 : cnt_ff;

   always_comb begin
      unique case (phase_ff)
         crfp_pkg::PH_SID1: sid_byte = sender_id_ff[23:16];
         crfp_pkg::PH_SID2: sid_byte = sender_id_ff[15:8];
         default:           sid_byte = sender_id_ff[7:0];
      endcase
   end

   // next phase
   always_comb begin
      unique case (phase_ff)
         crfp_pkg::PH_VERSION: step_phase = crfp_pkg::PH_SID1;
         crfp_pkg::PH_SID1:    step_phase = crfp_pkg::PH_SID2;
         crfp_pkg::PH_SID2:    step_phase = crfp_pkg::PH_SID3;
         crfp_pkg::PH_SID3:    step_phase = crfp_pkg::PH_COUNTER;
         crfp_pkg::PH_COUNTER: step_phase = crfp_pkg::PH_TYPE;
         crfp_pkg::PH_TYPE:    step_phase = is_term ? crfp_pkg::PH_SERIAL : crfp_pkg::PH_TYPE;
         crfp_pkg::PH_SERIAL:  step_phase = is_term ? crfp_pkg::PH_MARKER : crfp_pkg::PH_SERIAL;
         crfp_pkg::PH_MARKER:  step_phase = crfp_pkg::PH_OPCODE;
         crfp_pkg::PH_OPCODE:  step_phase = crfp_pkg::PH_RETCODE;
         default:              step_phase = crfp_pkg::PH_PAYLOAD;
      endcase
   end

   // per-byte tagging and frame flags
   always_comb begin
      kind_in          = crfp_pkg::KIND_PAYLOAD;
      pos_in           = 8'd0;
      cnt_in           = cnt_ff;
      step_version_bad = version_bad_ff;
      step_sender_bad  = sender_bad_ff;
      step_rc          = rc_ff;
      step_rc_seen     = rc_seen_ff;
      unique case (phase_ff) inside
         crfp_pkg::PH_VERSION: begin
            kind_in          = crfp_pkg::KIND_VERSION;
            step_version_bad = (req_frame_byte != crfp_pkg::VERSION_BYTE);
         end
         crfp_pkg::PH_SID1, crfp_pkg::PH_SID2, crfp_pkg::PH_SID3: begin
            if (phase_ff == crfp_pkg::PH_SID1) begin
               kind_in = crfp_pkg::KIND_SID1;
            end else if (phase_ff == crfp_pkg::PH_SID2) begin
               kind_in = crfp_pkg::KIND_SID2;
            end else begin
               kind_in = crfp_pkg::KIND_SID3;
            end
            if (sid_byte != req_frame_byte) begin
               step_sender_bad = 1'b1;
            end
         end
         crfp_pkg::PH_COUNTER: begin
            kind_in = crfp_pkg::KIND_COUNTER;
            cnt_in  = 8'd0;
         end
         crfp_pkg::PH_TYPE, crfp_pkg::PH_SERIAL: begin
            pos_in = cnt_ff;
            if (is_term) begin
               kind_in = (phase_ff == crfp_pkg::PH_TYPE) ? crfp_pkg::KIND_TYPE_END
                                                         : crfp_pkg::KIND_SERIAL_END;
               cnt_in  = 8'd0;
            end else begin
               kind_in = (phase_ff == crfp_pkg::PH_TYPE) ? crfp_pkg::KIND_TYPE_CHAR
                                                         : crfp_pkg::KIND_SERIAL_CHR;
               cnt_in  = cnt_bump;
            end
         end
         crfp_pkg::PH_MARKER: begin
            kind_in = crfp_pkg::KIND_MARKER;
         end
         crfp_pkg::PH_OPCODE: begin
            kind_in = crfp_pkg::KIND_OPCODE_RC;
            pos_in  = crfp_pkg::OPCODE_POS;
         end
         crfp_pkg::PH_RETCODE: begin
            kind_in      = crfp_pkg::KIND_OPCODE_RC;
            step_rc      = req_frame_byte;
            step_rc_seen = 1'b1;
            cnt_in       = 8'd0;
         end
         default: begin
            kind_in = crfp_pkg::KIND_PAYLOAD;
            pos_in  = cnt_ff;
            cnt_in  = cnt_bump;
         end
      endcase
      if (req_frame_end) begin
         cnt_in = 8'd0;
      end
   end

   // verdict on the final byte, after the byte is taken in
   always_comb begin
      verdict_in = crfp_pkg::VERDICT_OK;
      reboot_in  = 1'b0;
      if (req_frame_end) begin
         if (step_version_bad) begin
            verdict_in = crfp_pkg::VERDICT_BAD_VERSION;
         end else if (step_phase < crfp_pkg::PH_TYPE) begin
            verdict_in = crfp_pkg::VERDICT_TOO_SHORT;
         end else if (step_sender_bad) begin
            verdict_in = crfp_pkg::VERDICT_SENDER_BAD;
         end else if (step_phase < crfp_pkg::PH_MARKER) begin
            verdict_in = crfp_pkg::VERDICT_TOO_SHORT;
         end else if (!step_rc_seen) begin
            verdict_in = crfp_pkg::VERDICT_NO_RC;
         end else if (step_rc == crfp_pkg::RC_SUCCESS || step_rc == crfp_pkg::RC_REBOOT) begin
            verdict_in = crfp_pkg::VERDICT_OK;
            reboot_in  = (step_rc == crfp_pkg::RC_REBOOT);
         end else if (step_rc == crfp_pkg::RC_FAILED || step_rc == crfp_pkg::RC_FAILED_2) begin
            verdict_in = crfp_pkg::VERDICT_FAILED;
         end else begin
            verdict_in = crfp_pkg::VERDICT_UNKNOWN;
         end
      end
   end

   // a final byte drops all frame state
   assign phase_in       = req_frame_end ? crfp_pkg::PH_VERSION : step_phase;
   assign version_bad_in = req_frame_end ? 1'b0 : step_version_bad;
   assign sender_bad_in  = req_frame_end ? 1'b0 : step_sender_bad;
   assign rc_in          = req_frame_end ? 8'd0 : step_rc;
   assign rc_seen_in     = req_frame_end ? 1'b0 : step_rc_seen;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= crfp_pkg::PH_VERSION;
         cnt_ff         <= 8'd0;
         version_bad_ff <= 1'b0;
         sender_bad_ff  <= 1'b0;
         rc_ff          <= 8'd0;
         rc_seen_ff     <= 1'b0;
         sender_id_ff   <= 24'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sender_id_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            phase_ff       <= phase_in;
            cnt_ff         <= cnt_in;
            version_bad_ff <= version_bad_in;
            sender_bad_ff  <= sender_bad_in;
            rc_ff          <= rc_in;
            rc_seen_ff     <= rc_seen_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff    <= kind_in;
         pos_ff     <= pos_in;
         byte_ff    <= req_frame_byte;
         done_ff    <= req_frame_end;
         verdict_ff <= verdict_in;
         reboot_ff  <= reboot_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_kind  = kind_ff;
   assign rsp_field_pos   = pos_ff;
   assign rsp_byte_value  = byte_ff;
   assign rsp_frame_done  = done_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_reboot_flag = reboot_ff;

   `CRFP_ASSERT_NEXT(a_end_restarts, clock, reset, req_xfer && req_frame_end,
                     phase_ff == crfp_pkg::PH_VERSION && !rc_seen_ff)
   `CRFP_ASSERT_NOW(a_verdict_only_on_done, clock, reset, rsp_valid_ff && !done_ff,
                    verdict_ff == crfp_pkg::VERDICT_OK && !reboot_ff)
   `CRFP_ASSERT_NOW(a_reboot_is_ok, clock, reset, rsp_valid_ff && reboot_ff,
                    verdict_ff == crfp_pkg::VERDICT_OK && done_ff)
   `CRFP_ASSERT_NEXT(a_retcode_clears_pos, clock, reset,
                     req_xfer && phase_ff == crfp_pkg::PH_RETCODE, cnt_ff == 8'd0)

endmodule
